@@ design/knn_classifier_unit_macros.svh @@
// Assertion helpers shared by the checker.
`ifndef KNN_CLASSIFIER_UNIT_MACROS_SVH
`define KNN_CLASSIFIER_UNIT_MACROS_SVH
`define KNN_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define KNN_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

@@ design/knn_pkg.sv @@
`timescale 1ns / 1ps
package knn_pkg;
  localparam int unsigned DistW = 35;
  localparam int unsigned FeatW = 16;
  localparam int unsigned ClassW = 3;

  typedef enum logic [1:0] {
    CmdStore    = 2'd0,
    CmdClassify = 2'd1,
    CmdClear    = 2'd2,
    CmdNone     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StVote,
    StPick,
    StOut
  } state_e;

  localparam logic [0:0] RegK = 1'b0;
  localparam logic [0:0] RegCc = 1'b1;

  typedef struct packed {
    logic       start;
    logic       insert;
  } nb_ctl_t;
endpackage

@@ design/knn_dist.sv @@
`timescale 1ns / 1ps
module knn_dist (
  input  logic                                      clk_i,
  input  logic [4*knn_pkg::FeatW-1:0]               vec_i,
  input  logic [4*knn_pkg::FeatW-1:0]               query_i,
  input  logic [3:0]                                feat_en_i,
  output logic [knn_pkg::DistW-1:0]                 dist_o
);
  logic [3:0][32:0] sq_q;
  logic [3:0][16:0] mag;
  always_comb begin
    for (int f = 0; f < 4; f++) begin
      logic signed [16:0] d;
      d = 17'(signed'(vec_i[f*16 +: 16])) - 17'(signed'(query_i[f*16 +: 16]));
      mag[f] = d[16] ? 17'(-d) : 17'(d);
    end
  end
  always_ff @(posedge clk_i) begin
    for (int f = 0; f < 4; f++) begin
      sq_q[f] <= feat_en_i[f] ? 33'(34'(mag[f]) * 34'(mag[f])) : '0;
    end
  end
  assign dist_o = 35'(sq_q[0]) + 35'(sq_q[1]) + 35'(sq_q[2]) + 35'(sq_q[3]);
endmodule

@@ design/knn_nbr_list.sv @@
`timescale 1ns / 1ps
module knn_nbr_list #(
  parameter int unsigned MAX_K = 16,
  parameter int unsigned IDX_W = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  knn_pkg::nb_ctl_t             ctl_i,
  input  logic [$clog2(MAX_K+1)-1:0]   k_i,
  input  logic [knn_pkg::DistW-1:0]    dist_i,
  input  logic [IDX_W-1:0]             idx_i,
  input  logic [$clog2(MAX_K)-1:0]     rd_sel_i,
  output logic [IDX_W-1:0]             rd_idx_o,
  output logic [knn_pkg::DistW-1:0]    head_dist_o,
  output logic [IDX_W-1:0]             head_idx_o,
  output logic [$clog2(MAX_K+1)-1:0]   filled_o
);
  localparam int unsigned KW = $clog2(MAX_K+1);
  logic [MAX_K-1:0][knn_pkg::DistW-1:0] dist_q, dist_d;
  logic [MAX_K-1:0][IDX_W-1:0]          idx_q, idx_d;
  logic [KW-1:0]                        filled_q, filled_d;
  logic [MAX_K-1:0]                     less;

  always_comb begin
    dist_d = dist_q;
    idx_d = idx_q;
    filled_d = filled_q;
    for (int p = 0; p < MAX_K; p++) begin
      less[p] = (KW'(p) >= filled_q) || (dist_i < dist_q[p]);
    end
    if (ctl_i.start) begin
      filled_d = '0;
    end else if (ctl_i.insert) begin
      if (k_i != '0 && less[0]) begin
        dist_d[0] = dist_i;
        idx_d[0] = idx_i;
      end
      for (int p = 1; p < MAX_K; p++) begin
        if (KW'(p) < k_i && less[p]) begin
          if (!less[p-1]) begin
            dist_d[p] = dist_i;
            idx_d[p] = idx_i;
          end else begin
            dist_d[p] = dist_q[p-1];
            idx_d[p] = idx_q[p-1];
          end
        end
      end
      if (filled_q < k_i) filled_d = filled_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end
  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
    idx_q <= idx_d;
  end
  assign rd_idx_o = idx_q[rd_sel_i];
  assign head_dist_o = dist_q[0];
  assign head_idx_o = idx_q[0];
  assign filled_o = filled_q;
endmodule

@@ design/knn_classifier_unit.sv @@
`timescale 1ns / 1ps
// Store, clear and unknown commands leave the unit idle; the input is ready again the next cycle.
// A classify loads its result after the scan, drain, vote, pick and output states, in that order;
// the scan reads the stored vectors, the vote reads the neighbors found (at most k), and
// the pick walks the class count. Input stalls until the result leaves.
// Reset (rst_ni low, asynchronous) empties the store, sets k and class count to 3.
module knn_classifier_unit #(
  parameter int unsigned TRAIN_DEPTH = 256,
  parameter int unsigned MAX_K = 16,
  parameter int unsigned FEATURES = 4,
  parameter int unsigned MAX_CLASSES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[1:0], feature_0..3 [65:2], class_in [68:66], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // predicted_class[2:0], winning_votes[7:3], nearest_index[15:8], nearest_distance[49:16]
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int unsigned AW = (TRAIN_DEPTH > 1) ? $clog2(TRAIN_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TRAIN_DEPTH+1);
  localparam int unsigned KW = $clog2(MAX_K+1);
  localparam int unsigned SW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned VW = $clog2(MAX_CLASSES);
  localparam int unsigned NW = $clog2(MAX_K+1);

  logic [4:0] k_reg_q;
  logic [3:0] cc_reg_q;
  knn_pkg::state_e state_q, state_d;

  logic [63:0] vec_mem [TRAIN_DEPTH];
  logic [2:0]  cls_mem [TRAIN_DEPTH];
  logic [63:0] vec_rd_q;
  logic [2:0]  cls_rd_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] scan_q, scan_d;
  logic [AW-1:0] idx_p1_q, idx_p2_q;
  logic v_p1_q, v_p2_q;
  logic [63:0] query_q;
  logic [SW:0] vsel_q, vsel_d;
  logic vrd_q;
  logic [MAX_CLASSES-1:0][NW-1:0] votes_q;
  logic [VW:0] pick_q;
  logic [2:0] win_q;
  logic [55:0] out_q;
  logic out_v_q;

  logic [KW-1:0] k_eff, filled;
  logic [3:0] cc_eff;
  knn_pkg::nb_ctl_t ctl;
  logic [knn_pkg::DistW-1:0] scan_dist, head_dist;
  logic [7:0] head_idx_w;
  logic [AW-1:0] rd_idx, head_idx, rd_addr;
  logic accept;
  knn_pkg::cmd_e cmd;
  logic [3:0] fen;

  assign cmd = knn_pkg::cmd_e'(s_axis_tdata[1:0]);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == knn_pkg::StIdle) && !out_v_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == knn_pkg::RegCc) ? 32'(cc_reg_q) : 32'(k_reg_q);
  assign k_eff = (k_reg_q == 5'd0) ? KW'(1) :
                 (32'(k_reg_q) > MAX_K) ? KW'(MAX_K) : KW'(k_reg_q);
  assign cc_eff = (cc_reg_q == 4'd0) ? 4'd1 :
                  (32'(cc_reg_q) > MAX_CLASSES) ? 4'(MAX_CLASSES) : cc_reg_q;
  always_comb for (int f = 0; f < 4; f++) fen[f] = (f < FEATURES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_reg_q <= 5'd3;
      cc_reg_q <= 4'd3;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == knn_pkg::RegK) k_reg_q <= pwdata[4:0];
      else cc_reg_q <= pwdata[3:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      knn_pkg::StIdle:  if (accept && cmd == knn_pkg::CmdClassify) state_d = knn_pkg::StScan;
      knn_pkg::StScan:  if (scan_q >= count_q) state_d = knn_pkg::StDrain;
      knn_pkg::StDrain: if (!v_p1_q && !v_p2_q) state_d = knn_pkg::StVote;
      knn_pkg::StVote:  if (32'(vsel_q) >= 32'(filled) && !vrd_q) state_d = knn_pkg::StPick;
      knn_pkg::StPick:  if (32'(pick_q) >= 32'(cc_eff)) state_d = knn_pkg::StOut;
      knn_pkg::StOut:   state_d = knn_pkg::StIdle;
      default:          state_d = knn_pkg::StIdle;
    endcase
  end

  always_comb begin
    scan_d = scan_q;
    vsel_d = vsel_q;
    rd_addr = scan_q[AW-1:0];
    ctl = '0;
    ctl.start = accept && cmd == knn_pkg::CmdClassify;
    ctl.insert = v_p2_q;
    case (state_q)
      knn_pkg::StIdle: begin
        scan_d = '0;
        vsel_d = '0;
      end
      knn_pkg::StScan: if (scan_q < count_q) scan_d = scan_q + CW'(1);
      knn_pkg::StVote: begin
        rd_addr = rd_idx;
        if (32'(vsel_q) < 32'(filled)) vsel_d = vsel_q + (SW+1)'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= knn_pkg::StIdle;
      count_q <= '0;
      scan_q <= '0;
      vsel_q <= '0;
      v_p1_q <= 1'b0;
      v_p2_q <= 1'b0;
      vrd_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q <= scan_d;
      vsel_q <= vsel_d;
      v_p1_q <= (state_q == knn_pkg::StScan) && (scan_q < count_q);
      v_p2_q <= v_p1_q;
      vrd_q <= (state_q == knn_pkg::StVote) && (32'(vsel_q) < 32'(filled));
      if (accept && cmd == knn_pkg::CmdStore && 32'(count_q) < TRAIN_DEPTH)
        count_q <= count_q + CW'(1);
      else if (accept && cmd == knn_pkg::CmdClear) count_q <= '0;
      if (state_q == knn_pkg::StOut) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd == knn_pkg::CmdStore && 32'(count_q) < TRAIN_DEPTH) begin
      vec_mem[count_q[AW-1:0]] <= s_axis_tdata[65:2];
      cls_mem[count_q[AW-1:0]] <= s_axis_tdata[68:66];
    end
    vec_rd_q <= vec_mem[rd_addr];
    cls_rd_q <= cls_mem[rd_addr];
    idx_p1_q <= scan_q[AW-1:0];
    idx_p2_q <= idx_p1_q;
    if (accept) query_q <= s_axis_tdata[65:2];
    if (state_q == knn_pkg::StIdle) begin
      votes_q <= '0;
      pick_q <= (VW+1)'(1);
      win_q <= '0;
    end
    if (vrd_q && 32'(cls_rd_q) < 32'(cc_eff))
      votes_q[cls_rd_q[VW-1:0]] <= votes_q[cls_rd_q[VW-1:0]] + NW'(1);
    if (state_q == knn_pkg::StPick && 32'(pick_q) < 32'(cc_eff)) begin
      if (votes_q[pick_q[VW-1:0]] > votes_q[win_q[VW-1:0]]) win_q <= 3'(pick_q);
      pick_q <= pick_q + (VW+1)'(1);
    end
    if (state_q == knn_pkg::StOut) begin
      if (filled != '0) begin
        out_q <= {6'd0, head_dist[33:0], head_idx_w, 5'(votes_q[win_q[VW-1:0]]), win_q};
      end else begin
        out_q <= {6'd0, 34'd0, 8'd0, 5'(votes_q[win_q[VW-1:0]]), win_q};
      end
    end
  end

  knn_dist u_dist (
    .clk_i(clk_i), .vec_i(vec_rd_q), .query_i(query_q), .feat_en_i(fen), .dist_o(scan_dist)
  );

  logic [AW-1:0] rd_idx_w;
  knn_nbr_list #(.MAX_K(MAX_K), .IDX_W(AW)) u_list (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(ctl), .k_i(k_eff), .dist_i(scan_dist),
    .idx_i(idx_p2_q), .rd_sel_i(vsel_q[SW-1:0]), .rd_idx_o(rd_idx_w),
    .head_dist_o(head_dist), .head_idx_o(head_idx), .filled_o(filled)
  );
  assign rd_idx = rd_idx_w;
  assign head_idx_w = 8'(head_idx);

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;
endmodule

@@ design/knn_classifier_unit_checker.sv @@
`timescale 1ns / 1ps
`include "knn_classifier_unit_macros.svh"
module knn_classifier_unit_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  `KNN_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `KNN_ASSERT_IMP(a_busy, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `KNN_ASSERT_IMP(a_votes, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[7:3] <= 5'd16)
  `KNN_ASSERT_IMP(a_pad, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[55:50] == 6'd0)
endmodule

bind knn_classifier_unit knn_classifier_unit_checker u_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps
module tb;
  localparam int Depth = 256;
  localparam int MaxK = 16;
  localparam int MaxCls = 8;
  localparam int StallLimit = 20000;

  typedef struct packed {
    logic [2:0]     cls;
    logic [15:0]    f3;
    logic [15:0]    f2;
    logic [15:0]    f1;
    logic [15:0]    f0;
    knn_pkg::cmd_e  cmd;
  } knn_req_t;

  typedef struct packed {
    logic [33:0] near_dist;
    logic [7:0]  near;
    logic [4:0]  votes;
    logic [2:0]  cls;
  } knn_ans_t;

  class knn_board;
    logic [63:0] vec_mem[Depth];
    logic [2:0]  cls_mem[Depth];
    int unsigned stored;
    logic [4:0]  k_reg;
    logic [3:0]  cc_reg;
    knn_ans_t    pending[$];
    int          errors;

    function void init();
      stored = 0;
      k_reg = 5'd3;
      cc_reg = 4'd3;
      errors = 0;
    endfunction

    function logic [34:0] sq_dist(logic [63:0] v, knn_req_t r);
      logic [34:0] s;
      logic signed [16:0] d;
      logic [63:0] q;
      longint dd;
      s = '0;
      q = {r.f3, r.f2, r.f1, r.f0};
      for (int f = 0; f < 4; f++) begin
        d = $signed(v[16*f +: 16]) - $signed(q[16*f +: 16]);
        dd = longint'(d);
        s += 35'(dd * dd);
      end
      return s;
    endfunction

    function void note_input(knn_req_t r);
      logic [34:0] nd[MaxK];
      int ni[MaxK];
      int votes[MaxCls];
      int k, cc, filled, p, j, win;
      logic [34:0] d;
      knn_ans_t a;
      case (r.cmd)
        knn_pkg::CmdStore: begin
          if (stored < Depth) begin
            vec_mem[stored] = {r.f3, r.f2, r.f1, r.f0};
            cls_mem[stored] = r.cls;
            stored++;
          end
        end
        knn_pkg::CmdClear: stored = 0;
        knn_pkg::CmdClassify: begin
          k = (k_reg < 1) ? 1 : (k_reg > MaxK) ? MaxK : k_reg;
          cc = (cc_reg < 1) ? 1 : (cc_reg > MaxCls) ? MaxCls : cc_reg;
          for (int i = 0; i < MaxK; i++) begin
            nd[i] = '1;
            ni[i] = 0;
          end
          for (int i = 0; i < MaxCls; i++) votes[i] = 0;
          filled = 0;
          for (int t = 0; t < stored; t++) begin
            d = sq_dist(vec_mem[t], r);
            p = 0;
            while (p < filled && !(d < nd[p])) p++;
            if (p < k) begin
              j = (filled < k) ? filled : k - 1;
              while (j > p) begin
                nd[j] = nd[j-1];
                ni[j] = ni[j-1];
                j--;
              end
              nd[p] = d;
              ni[p] = t;
              if (filled < k) filled++;
            end
          end
          for (int i = 0; i < filled; i++)
            if (cls_mem[ni[i]] < cc) votes[cls_mem[ni[i]]]++;
          win = 0;
          for (int i = 1; i < cc; i++)
            if (votes[i] > votes[win]) win = i;
          a.cls = 3'(win);
          a.votes = 5'(votes[win]);
          a.near = (filled > 0) ? 8'(ni[0]) : 8'd0;
          a.near_dist = (filled > 0) ? nd[0][33:0] : 34'd0;
          pending.push_back(a);
        end
        default: ;
      endcase
    endfunction

    function void check_result(knn_ans_t got);
      knn_ans_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp cls %0d votes %0d idx %0d dist %0d, got %0d %0d %0d %0d",
                   e.cls, e.votes, e.near, e.near_dist,
                   got.cls, got.votes, got.near, got.near_dist);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [55:0] m_axis_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  knn_board board = new();
  int idle_cycles = 0;
  bit hold_off = 0;
  bit rx_random = 1;

  always #5 clk_i = ~clk_i;

  knn_classifier_unit dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_result(knn_ans_t'(m_axis_tdata[49:0]));
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else if (!rx_random) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'd0) board.k_reg = val[4:0];
    else board.cc_reg = val[3:0];
  endtask

  task automatic send(knn_req_t r);
    s_axis_tdata <= {3'b0, r};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(r);
  endtask

  task automatic pause_out();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    pause_out();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  function automatic knn_req_t mk(knn_pkg::cmd_e c, logic [15:0] a, logic [15:0] b,
                                  logic [15:0] x, logic [15:0] y, logic [2:0] cl);
    knn_req_t r;
    r.cmd = c; r.f0 = a; r.f1 = b; r.f2 = x; r.f3 = y; r.cls = cl;
    return r;
  endfunction

  function automatic logic [15:0] rfeat(int spread);
    if (spread) return 16'($urandom);
    return 16'($urandom_range(0, 15)) - 16'd8;
  endfunction

  function automatic knn_req_t rand_req(int stores_weight);
    int w;
    knn_pkg::cmd_e c;
    w = $urandom_range(0, 99);
    c = w < stores_weight ? knn_pkg::CmdStore :
        (w < 97 ? knn_pkg::CmdClassify : (w < 99 ? knn_pkg::CmdClear : knn_pkg::CmdNone));
    return mk(c, rfeat(w & 1), rfeat(w & 2), rfeat(w & 4), rfeat(w & 8), 3'($urandom));
  endfunction

  initial begin
    int n;
    board.init();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(mk(knn_pkg::CmdClassify, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0));
    send(mk(knn_pkg::CmdStore, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 3'd7));
    send(mk(knn_pkg::CmdStore, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd0));
    send(mk(knn_pkg::CmdStore, 16'h0001, 16'h0, 16'h0, 16'h0, 3'd1));
    send(mk(knn_pkg::CmdStore, 16'hffff, 16'h0, 16'h0, 16'h0, 3'd2));
    send(mk(knn_pkg::CmdClassify, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3'd5));
    send(mk(knn_pkg::CmdClassify, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 3'd0));
    send(mk(knn_pkg::CmdClassify, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0));
    send(mk(knn_pkg::CmdNone, 16'h1234, 16'h0, 16'h0, 16'h0, 3'd3));
    send(mk(knn_pkg::CmdClear, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0));
    send(mk(knn_pkg::CmdClassify, 16'h5, 16'h0, 16'h0, 16'h0, 3'd0));
    drain();

    reg_write(3'd0, 32'd0);
    reg_write(3'd4, 32'd0);
    send(mk(knn_pkg::CmdStore, 16'h1, 16'h0, 16'h0, 16'h0, 3'd1));
    send(mk(knn_pkg::CmdStore, 16'h1, 16'h0, 16'h0, 16'h0, 3'd0));
    send(mk(knn_pkg::CmdClassify, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0));
    drain();
    reg_write(3'd0, 32'd31);
    reg_write(3'd4, 32'd15);
    for (int i = 0; i < 260; i++)
      send(mk(knn_pkg::CmdStore, rfeat(0), rfeat(0), 16'h0, 16'h0, 3'($urandom)));
    send(mk(knn_pkg::CmdClassify, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0));
    send(mk(knn_pkg::CmdClear, 16'h0, 16'h0, 16'h0, 16'h0, 3'd0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin reg_write(3'd0, 32'd1); reg_write(3'd4, 32'd8); end
        1: begin reg_write(3'd0, 32'd16); reg_write(3'd4, 32'd1); end
        2: begin reg_write(3'd0, 32'd5); reg_write(3'd4, 32'd4); end
        3: begin reg_write(3'd0, 32'd3); reg_write(3'd4, 32'd3); end
        4: begin reg_write(3'd0, 32'd17); reg_write(3'd4, 32'd9); end
        default: begin reg_write(3'd0, 32'd8); reg_write(3'd4, 32'd6); end
      endcase
      rx_random = (phase != 3);
      n = 0;
      while (n < 220) begin
        if (phase == 2 && n == 100) begin
          fork
            begin
              hold_off = 1;
              repeat (3000) @(posedge clk_i);
              hold_off = 0;
            end
          join_none
        end
        if ($urandom_range(0, 3) == 0) begin
          pause_out();
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
        if (n == 150 && phase == 4) begin
          pause_out();
          while (board.pending.size() != 0) @(posedge clk_i);
        end
        send(rand_req(board.stored < 40 ? 70 : 25));
        n++;
      end
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
